// ===== hdl/rbspe_pkg.sv =====
// shared types, constants and helpers of the rational b-spline point evaluator
`timescale 1ns / 1ps

package rbspe_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 7;
    localparam int COORD_BITS_DEF = 32;

    localparam int HX_W = 41;   // homogeneous coordinate
    localparam int WT_W = 24;   // weight, q8.16
    localparam int AL_W = 17;   // alpha, q0.16 up to 1.0
    localparam int PR_W = 66;   // shared multiplier product
    localparam int DQ_W = 57;   // divider dividend / quotient
    localparam int RM_W = 34;   // divider partial remainder
    localparam int DS_W = 33;   // divider divisor
    localparam int DC_W = 6;    // divider step counter

    localparam logic [DC_W-1:0] ALPHA_STEPS = 6'd16;
    localparam logic [DC_W-1:0] HDIV_STEPS  = 6'd57;
    localparam logic [AL_W-1:0] FIX_ONE     = 17'd65536;

    localparam logic [2:0] DEGREE_RST = 3'd3;

    localparam logic [1:0] CFG_DEGREE   = 2'd0;
    localparam logic [1:0] CFG_COUNT    = 2'd1;
    localparam logic [1:0] CFG_RATIONAL = 2'd2;

    typedef enum logic [1:0] {
        CMD_EVAL   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_KNOT   = 2'd2,
        CMD_WEIGHT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DK_ALPHA,
        DK_X,
        DK_Y
    } t_dkind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_FB_CAP,
        ST_LO_CAP,
        ST_HI_CAP,
        ST_SR_B,
        ST_SR_C,
        ST_LD_RD,
        ST_LD_MX,
        ST_LD_MY,
        ST_LD_WR,
        ST_BL_RD,
        ST_BL_K1,
        ST_BL_K2,
        ST_DIV,
        ST_AL_FIN,
        ST_BL_MX,
        ST_BL_MY,
        ST_BL_MW,
        ST_BL_WR,
        ST_FN_RD,
        ST_FN_CAP,
        ST_HD_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [HX_W-1:0] x;
        logic signed [HX_W-1:0] y;
        logic [WT_W-1:0]        w;
    } t_hpoint;

    localparam int HP_W = $bits(t_hpoint);

    // round half up at 16 fractional bits
    function automatic logic signed [HX_W-1:0] rnd16(input logic signed [PR_W-1:0] v);
        logic signed [PR_W-1:0] t;
        t = v + PR_W'(32768);
        return t[HX_W+15:16];
    endfunction

endpackage

// ===== hdl/rational_bspline_point_eval.sv =====
// top level: rational b-spline point evaluator, de boor on one shared multiplier and divider
`timescale 1ns / 1ps

// write transactions (point, knot, weight) are taken back to back while the block is idle
// an evaluate transaction runs de boor on the shared 1-bit-per-cycle divider and the single
//   multiplier: a divide for each alpha that is not 0 or 1.0, then a final divide for x and y
//   each; an invalid setup answers from the check state, through the fallback capture when
//   points exist; the block takes one item at a time
// synchronous active-low reset clears control state and the registers (degree 3, count 0,
// rational off); the point, weight and knot stores keep no reset and must be written first

module rational_bspline_point_eval #(
    parameter int MAX_POINTS = rbspe_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = rbspe_pkg::MAX_DEGREE_DEF,
    parameter int COORD_BITS = rbspe_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot[6:0], point_x[38:7], point_y[70:39], knot_value[102:71],
    // weight_value[126:103], u_param[158:127], zero pad [159]
    input  logic [159:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // curve_x[31:0], curve_y[63:32]
    output logic [63:0]  m_tdata,
    // fallback[0], weight_zero[1]
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int PA_W  = $clog2(MAX_POINTS);
    localparam int KA_W  = $clog2(KNOT_DEPTH);
    localparam int DG_W  = $clog2(MAX_DEGREE + 1);
    localparam int IW    = $clog2(KNOT_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam int HX_W = rbspe_pkg::HX_W;
    localparam int WT_W = rbspe_pkg::WT_W;
    localparam int AL_W = rbspe_pkg::AL_W;
    localparam int PR_W = rbspe_pkg::PR_W;
    localparam int DQ_W = rbspe_pkg::DQ_W;
    localparam int RM_W = rbspe_pkg::RM_W;
    localparam int DS_W = rbspe_pkg::DS_W;
    localparam int DC_W = rbspe_pkg::DC_W;

    // saturate to a signed COORD_BITS value, deliver the low 32 bits
    function automatic logic [31:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] s;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            s = hi;
        end else if (v < lo) begin
            s = lo;
        end else begin
            s = v;
        end
        return s[31:0];
    endfunction

    // input fields
    logic [6:0]          in_slot;
    logic [31:0]         in_px;
    logic [31:0]         in_py;
    logic [31:0]         in_knot;
    logic [WT_W-1:0]     in_wv;
    logic signed [31:0]  in_u;
    rbspe_pkg::t_cmd     in_cmd;
    logic                accept;

    assign in_slot = s_tdata[6:0];
    assign in_px   = s_tdata[38:7];
    assign in_py   = s_tdata[70:39];
    assign in_knot = s_tdata[102:71];
    assign in_wv   = s_tdata[126:103];
    assign in_u    = $signed(s_tdata[158:127]);
    assign in_cmd  = rbspe_pkg::t_cmd'(s_tuser);

    // configuration registers
    logic [2:0] r_degree;
    logic [6:0] r_count;
    logic       r_rational;
    logic       cfg_we;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= rbspe_pkg::DEGREE_RST;
            r_count    <= 7'd0;
            r_rational <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                rbspe_pkg::CFG_DEGREE:   r_degree   <= pwdata[2:0];
                rbspe_pkg::CFG_COUNT:    r_count    <= pwdata[6:0];
                rbspe_pkg::CFG_RATIONAL: r_rational <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rbspe_pkg::CFG_DEGREE:   prdata = {29'd0, r_degree};
            rbspe_pkg::CFG_COUNT:    prdata = {25'd0, r_count};
            rbspe_pkg::CFG_RATIONAL: prdata = {31'd0, r_rational};
            default:                 prdata = 32'd0;
        endcase
    end

    // sequencer and datapath registers
    rbspe_pkg::t_state  r_state, n_state;
    rbspe_pkg::t_dkind  r_dkind, n_dkind;
    logic [DG_W-1:0]    r_p, n_p;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic signed [31:0] r_u, n_u;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_k, n_k;
    logic [DG_W-1:0]    r_j, n_j;
    logic [DG_W-1:0]    r_r, n_r;
    logic signed [31:0] r_kprev, n_kprev;
    logic signed [31:0] r_base, n_base;
    logic [AL_W-1:0]    r_alpha, n_alpha;
    rbspe_pkg::t_hpoint r_dprev, n_dprev;
    rbspe_pkg::t_hpoint r_dcur, n_dcur;
    logic signed [HX_W-1:0] r_hx, n_hx;
    logic signed [HX_W-1:0] r_hy, n_hy;
    logic signed [PR_W-1:0] r_prod, n_prod;
    logic [DQ_W-1:0]    r_dq, n_dq;
    logic [RM_W-1:0]    r_rem, n_rem;
    logic [DS_W-1:0]    r_dsr, n_dsr;
    logic [DC_W-1:0]    r_dcnt, n_dcnt;
    logic               r_hneg, n_hneg;
    logic [31:0]        r_rx, n_rx;
    logic [31:0]        r_ry, n_ry;
    logic               r_fb, n_fb;
    logic               r_wz, n_wz;
    logic               r_m_valid, n_m_valid;
    logic [63:0]        r_m_data, n_m_data;
    logic [1:0]         r_m_user, n_m_user;

    // memories
    logic               pt_we, wt_we, kn_we, d_we;
    logic [PA_W-1:0]    pt_raddr;
    logic [KA_W-1:0]    kn_raddr;
    logic [DG_W-1:0]    d_raddr;
    logic [63:0]        pt_rdata;
    logic [WT_W-1:0]    wt_rdata;
    logic [31:0]        kn_rdata_raw;
    logic [rbspe_pkg::HP_W-1:0] d_rdata_raw;
    logic [rbspe_pkg::HP_W-1:0] d_wdata;
    logic signed [31:0] kn_rdata;
    rbspe_pkg::t_hpoint d_rdata;

    assign accept   = s_tvalid & s_tready;
    assign pt_we    = accept && (in_cmd == rbspe_pkg::CMD_POINT) && (32'(in_slot) < MAX_POINTS);
    assign wt_we    = accept && (in_cmd == rbspe_pkg::CMD_WEIGHT) && (32'(in_slot) < MAX_POINTS);
    assign kn_we    = accept && (in_cmd == rbspe_pkg::CMD_KNOT) && (32'(in_slot) < KNOT_DEPTH);
    assign kn_rdata = $signed(kn_rdata_raw);
    assign d_rdata  = rbspe_pkg::t_hpoint'(d_rdata_raw);

    rbspe_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (PA_W'(in_slot)),
        .i_wdata ({in_py, in_px}),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    rbspe_ram #(.WIDTH(WT_W), .DEPTH(MAX_POINTS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (PA_W'(in_slot)),
        .i_wdata (in_wv),
        .i_raddr (pt_raddr),
        .o_rdata (wt_rdata)
    );

    rbspe_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_kn_ram (
        .i_clk   (i_clk),
        .i_we    (kn_we),
        .i_waddr (KA_W'(in_slot)),
        .i_wdata (in_knot),
        .i_raddr (kn_raddr),
        .o_rdata (kn_rdata_raw)
    );

    // de boor working points d[0..p]
    rbspe_ram #(.WIDTH(rbspe_pkg::HP_W), .DEPTH(MAX_DEGREE + 1)) u_d_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_j),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata_raw)
    );

    // index arithmetic
    logic [IW-1:0] idx;       // k - p + j
    logic [IW-1:0] ki2;       // k + j - r + 1
    logic [IW-1:0] last_i;    // n = count - 1
    logic          setup_bad;

    assign idx       = r_k - IW'(r_p) + IW'(r_j);
    assign ki2       = r_k + IW'(r_j) - IW'(r_r) + IW'(1);
    assign last_i    = IW'(r_cnt) - IW'(1);
    assign setup_bad = IW'(r_cnt) < (IW'(r_p) + IW'(1));

    // weight in use for the point being loaded
    logic [WT_W-1:0] w_eff;
    assign w_eff = r_rational ? wt_rdata : WT_W'(rbspe_pkg::FIX_ONE);

    // shared multiplier operands
    logic signed [HX_W-1:0] mul_a;
    logic signed [WT_W:0]   mul_b;

    // shared divider step
    logic [RM_W-1:0] div_t;
    logic            div_ge;
    logic            div_rnd;
    assign div_t   = {r_rem[RM_W-2:0], r_dq[DQ_W-1]};
    assign div_ge  = div_t >= {1'b0, r_dsr};
    assign div_rnd = {r_rem[RM_W-2:0], 1'b0} >= {1'b0, r_dsr};

    // alpha operands
    logic signed [32:0] al_num, al_den;
    logic [32:0]        al_an, al_ad;
    assign al_num = $signed({r_u[31], r_u}) - $signed({r_base[31], r_base});
    assign al_den = $signed({kn_rdata[31], kn_rdata}) - $signed({r_base[31], r_base});
    assign al_an  = al_num[32] ? 33'(-al_num) : 33'(al_num);
    assign al_ad  = al_den[32] ? 33'(-al_den) : 33'(al_den);

    // final divide result
    logic [DQ_W:0]      hd_mag;
    logic signed [63:0] hd_val;
    assign hd_mag = {1'b0, r_dq} + (DQ_W + 1)'(div_rnd);
    assign hd_val = r_hneg ? (64'sd0 - $signed(64'(hd_mag))) : $signed(64'(hd_mag));

    // search compare
    logic sr_found, sr_last;
    assign sr_found = (r_u >= r_kprev) && (r_u < kn_rdata);
    assign sr_last  = (r_i == last_i);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbspe_pkg::ST_IDLE: begin
                if (accept && (in_cmd == rbspe_pkg::CMD_EVAL)) begin
                    n_state = rbspe_pkg::ST_CHK;
                end
            end
            rbspe_pkg::ST_CHK: begin
                if (!setup_bad) begin
                    n_state = rbspe_pkg::ST_LO_CAP;
                end else if (r_cnt == '0) begin
                    n_state = rbspe_pkg::ST_OUT;
                end else begin
                    n_state = rbspe_pkg::ST_FB_CAP;
                end
            end
            rbspe_pkg::ST_FB_CAP: n_state = rbspe_pkg::ST_OUT;
            rbspe_pkg::ST_LO_CAP: n_state = rbspe_pkg::ST_HI_CAP;
            rbspe_pkg::ST_HI_CAP: n_state = rbspe_pkg::ST_SR_B;
            rbspe_pkg::ST_SR_B:   n_state = rbspe_pkg::ST_SR_C;
            rbspe_pkg::ST_SR_C: begin
                if (sr_found || sr_last) begin
                    n_state = rbspe_pkg::ST_LD_RD;
                end
            end
            rbspe_pkg::ST_LD_RD: n_state = rbspe_pkg::ST_LD_MX;
            rbspe_pkg::ST_LD_MX: n_state = rbspe_pkg::ST_LD_MY;
            rbspe_pkg::ST_LD_MY: n_state = rbspe_pkg::ST_LD_WR;
            rbspe_pkg::ST_LD_WR: begin
                if (r_j != r_p) begin
                    n_state = rbspe_pkg::ST_LD_RD;
                end else if (r_p == '0) begin
                    n_state = rbspe_pkg::ST_FN_RD;
                end else begin
                    n_state = rbspe_pkg::ST_BL_RD;
                end
            end
            rbspe_pkg::ST_BL_RD: n_state = rbspe_pkg::ST_BL_K1;
            rbspe_pkg::ST_BL_K1: n_state = rbspe_pkg::ST_BL_K2;
            rbspe_pkg::ST_BL_K2: begin
                if ((al_den == '0) || (al_num == '0) || (al_num[32] != al_den[32])
                        || (al_an >= al_ad)) begin
                    n_state = rbspe_pkg::ST_BL_MX;
                end else begin
                    n_state = rbspe_pkg::ST_DIV;
                end
            end
            rbspe_pkg::ST_DIV: begin
                if (r_dcnt == DC_W'(1)) begin
                    if (r_dkind == rbspe_pkg::DK_ALPHA) begin
                        n_state = rbspe_pkg::ST_AL_FIN;
                    end else begin
                        n_state = rbspe_pkg::ST_HD_FIN;
                    end
                end
            end
            rbspe_pkg::ST_AL_FIN: n_state = rbspe_pkg::ST_BL_MX;
            rbspe_pkg::ST_BL_MX:  n_state = rbspe_pkg::ST_BL_MY;
            rbspe_pkg::ST_BL_MY:  n_state = rbspe_pkg::ST_BL_MW;
            rbspe_pkg::ST_BL_MW:  n_state = rbspe_pkg::ST_BL_WR;
            rbspe_pkg::ST_BL_WR: begin
                if ((r_j == r_r) && (r_r == r_p)) begin
                    n_state = rbspe_pkg::ST_FN_RD;
                end else begin
                    n_state = rbspe_pkg::ST_BL_RD;
                end
            end
            rbspe_pkg::ST_FN_RD: n_state = rbspe_pkg::ST_FN_CAP;
            rbspe_pkg::ST_FN_CAP: begin
                if (d_rdata.w == '0) begin
                    n_state = rbspe_pkg::ST_OUT;
                end else begin
                    n_state = rbspe_pkg::ST_DIV;
                end
            end
            rbspe_pkg::ST_HD_FIN: begin
                if (r_dkind == rbspe_pkg::DK_X) begin
                    n_state = rbspe_pkg::ST_DIV;
                end else begin
                    n_state = rbspe_pkg::ST_OUT;
                end
            end
            rbspe_pkg::ST_OUT: begin
                if (!r_m_valid || m_tready) begin
                    n_state = rbspe_pkg::ST_IDLE;
                end
            end
            default: n_state = rbspe_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: memory addresses, strobes and multiplier operands
    always_comb begin
        s_tready = (r_state == rbspe_pkg::ST_IDLE);
        pt_raddr = '0;
        kn_raddr = KA_W'(idx);
        d_raddr  = r_j;
        d_we     = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            rbspe_pkg::ST_CHK:    kn_raddr = KA_W'(r_p);
            rbspe_pkg::ST_LO_CAP: kn_raddr = KA_W'(r_cnt);
            rbspe_pkg::ST_HI_CAP: kn_raddr = KA_W'(r_p);
            rbspe_pkg::ST_SR_B:   kn_raddr = KA_W'(r_i + IW'(1));
            rbspe_pkg::ST_SR_C:   kn_raddr = KA_W'(r_i + IW'(2));
            rbspe_pkg::ST_LD_RD: begin
                pt_raddr = PA_W'(idx);
            end
            rbspe_pkg::ST_LD_MX: begin
                pt_raddr = PA_W'(idx);
                mul_a    = HX_W'($signed(pt_rdata[31:0]));
                mul_b    = $signed({1'b0, w_eff});
            end
            rbspe_pkg::ST_LD_MY: begin
                pt_raddr = PA_W'(idx);
                mul_a    = HX_W'($signed(pt_rdata[63:32]));
                mul_b    = $signed({1'b0, w_eff});
            end
            rbspe_pkg::ST_LD_WR: begin
                pt_raddr = PA_W'(idx);
                d_we     = 1'b1;
            end
            rbspe_pkg::ST_BL_RD: d_raddr = r_j - DG_W'(1);
            rbspe_pkg::ST_BL_K1: kn_raddr = KA_W'(ki2);
            rbspe_pkg::ST_BL_MX: begin
                mul_a = r_dcur.x - r_dprev.x;
                mul_b = $signed({{(WT_W + 1 - AL_W){1'b0}}, r_alpha});
            end
            rbspe_pkg::ST_BL_MY: begin
                mul_a = r_dcur.y - r_dprev.y;
                mul_b = $signed({{(WT_W + 1 - AL_W){1'b0}}, r_alpha});
            end
            rbspe_pkg::ST_BL_MW: begin
                mul_a = HX_W'($signed({1'b0, r_dcur.w}) - $signed({1'b0, r_dprev.w}));
                mul_b = $signed({{(WT_W + 1 - AL_W){1'b0}}, r_alpha});
            end
            rbspe_pkg::ST_BL_WR: d_we = 1'b1;
            rbspe_pkg::ST_FN_RD: d_raddr = r_p;
            default: ;
        endcase
    end

    // write data for the working points
    logic signed [HX_W-1:0] bl_res;
    assign bl_res = r_dprev.w + rbspe_pkg::rnd16(r_prod);

    always_comb begin
        if (r_state == rbspe_pkg::ST_LD_WR) begin
            d_wdata = {r_hx, rbspe_pkg::rnd16(r_prod), w_eff};
        end else begin
            d_wdata = {r_hx, r_hy, bl_res[WT_W-1:0]};
        end
    end

    // datapath next values
    always_comb begin
        n_dkind   = r_dkind;
        n_p       = r_p;
        n_cnt     = r_cnt;
        n_u       = r_u;
        n_i       = r_i;
        n_k       = r_k;
        n_j       = r_j;
        n_r       = r_r;
        n_kprev   = r_kprev;
        n_base    = r_base;
        n_alpha   = r_alpha;
        n_dprev   = r_dprev;
        n_dcur    = r_dcur;
        n_hx      = r_hx;
        n_hy      = r_hy;
        n_prod    = mul_a * mul_b;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_dsr     = r_dsr;
        n_dcnt    = r_dcnt;
        n_hneg    = r_hneg;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_fb      = r_fb;
        n_wz      = r_wz;
        n_m_valid = r_m_valid & ~m_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        case (r_state)
            rbspe_pkg::ST_IDLE: begin
                // clamp oversized registers at the start of an evaluate
                n_p   = (32'(r_degree) > MAX_DEGREE) ? DG_W'(MAX_DEGREE) : DG_W'(r_degree);
                n_cnt = (32'(r_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(r_count);
                n_u   = in_u;
            end
            rbspe_pkg::ST_CHK: begin
                n_fb = setup_bad;
                n_wz = 1'b0;
                n_rx = 32'd0;
                n_ry = 32'd0;
            end
            rbspe_pkg::ST_FB_CAP: begin
                n_rx = sat_out(64'($signed(pt_rdata[31:0])));
                n_ry = sat_out(64'($signed(pt_rdata[63:32])));
            end
            rbspe_pkg::ST_LO_CAP: begin
                if (r_u < kn_rdata) begin
                    n_u = kn_rdata;
                end
            end
            rbspe_pkg::ST_HI_CAP: begin
                if (r_u > kn_rdata) begin
                    n_u = kn_rdata;
                end
                n_i = IW'(r_p);
            end
            rbspe_pkg::ST_SR_B: n_kprev = kn_rdata;
            rbspe_pkg::ST_SR_C: begin
                // no span found falls back to the last span, i = n
                if (sr_found || sr_last) begin
                    n_k = r_i;
                    n_j = '0;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_kprev = kn_rdata;
                end
            end
            rbspe_pkg::ST_LD_MY: n_hx = rbspe_pkg::rnd16(r_prod);
            rbspe_pkg::ST_LD_WR: begin
                if (r_j == r_p) begin
                    n_r = DG_W'(1);
                end else begin
                    n_j = r_j + DG_W'(1);
                end
            end
            rbspe_pkg::ST_BL_K1: begin
                n_base  = kn_rdata;
                n_dprev = d_rdata;
            end
            rbspe_pkg::ST_BL_K2: begin
                n_dcur = d_rdata;
                if ((al_den == '0) || (al_num == '0) || (al_num[32] != al_den[32])) begin
                    n_alpha = '0;
                end else if (al_an >= al_ad) begin
                    n_alpha = rbspe_pkg::FIX_ONE;
                end else begin
                    n_rem   = RM_W'(al_an);
                    n_dq    = '0;
                    n_dsr   = al_ad;
                    n_dcnt  = rbspe_pkg::ALPHA_STEPS;
                    n_dkind = rbspe_pkg::DK_ALPHA;
                end
            end
            rbspe_pkg::ST_DIV: begin
                n_rem  = div_ge ? (div_t - {1'b0, r_dsr}) : div_t;
                n_dq   = {r_dq[DQ_W-2:0], div_ge};
                n_dcnt = r_dcnt - DC_W'(1);
            end
            rbspe_pkg::ST_AL_FIN: n_alpha = r_dq[AL_W-2:0] + AL_W'(div_rnd);
            rbspe_pkg::ST_BL_MY: n_hx = r_dprev.x + rbspe_pkg::rnd16(r_prod);
            rbspe_pkg::ST_BL_MW: n_hy = r_dprev.y + rbspe_pkg::rnd16(r_prod);
            rbspe_pkg::ST_BL_WR: begin
                if (r_j == r_r) begin
                    n_r = r_r + DG_W'(1);
                    n_j = r_p;
                end else begin
                    n_j = r_j - DG_W'(1);
                end
            end
            rbspe_pkg::ST_FN_CAP: begin
                n_dcur = d_rdata;
                if (d_rdata.w == '0) begin
                    // zero weight: homogeneous coordinates go out undivided
                    n_wz = 1'b1;
                    n_rx = sat_out(64'(d_rdata.x));
                    n_ry = sat_out(64'(d_rdata.y));
                end else begin
                    n_hneg  = d_rdata.x[HX_W-1];
                    n_rem   = '0;
                    n_dq    = DQ_W'(d_rdata.x[HX_W-1] ? -d_rdata.x : d_rdata.x) << 16;
                    n_dsr   = DS_W'(d_rdata.w);
                    n_dcnt  = rbspe_pkg::HDIV_STEPS;
                    n_dkind = rbspe_pkg::DK_X;
                end
            end
            rbspe_pkg::ST_HD_FIN: begin
                if (r_dkind == rbspe_pkg::DK_X) begin
                    n_rx    = sat_out(hd_val);
                    n_hneg  = r_dcur.y[HX_W-1];
                    n_rem   = '0;
                    n_dq    = DQ_W'(r_dcur.y[HX_W-1] ? -r_dcur.y : r_dcur.y) << 16;
                    n_dcnt  = rbspe_pkg::HDIV_STEPS;
                    n_dkind = rbspe_pkg::DK_Y;
                end else begin
                    n_ry = sat_out(hd_val);
                end
            end
            rbspe_pkg::ST_OUT: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_ry, r_rx};
                    n_m_user  = {r_wz, r_fb};
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rbspe_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_dkind  <= n_dkind;
        r_p      <= n_p;
        r_cnt    <= n_cnt;
        r_u      <= n_u;
        r_i      <= n_i;
        r_k      <= n_k;
        r_j      <= n_j;
        r_r      <= n_r;
        r_kprev  <= n_kprev;
        r_base   <= n_base;
        r_alpha  <= n_alpha;
        r_dprev  <= n_dprev;
        r_dcur   <= n_dcur;
        r_hx     <= n_hx;
        r_hy     <= n_hy;
        r_prod   <= n_prod;
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_dsr    <= n_dsr;
        r_dcnt   <= n_dcnt;
        r_hneg   <= n_hneg;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_fb     <= n_fb;
        r_wz     <= n_wz;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

endmodule

// ===== hdl/rbspe_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rbspe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_rational_bspline_point_eval.sv =====
// testbench for the rational b-spline point evaluator: directed and random checks against a predictor
`timescale 1ns / 1ps

module tb_rational_bspline_point_eval;

    localparam int NPTS  = 64;
    localparam int NKNOT = 72;
    localparam longint ONE_Q16 = 65536;

    // one input transaction, unpacked
    typedef struct {
        rbspe_pkg::t_cmd  cmd;
        logic [6:0]       slot;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      knot;
        logic [23:0]      wgt;
        logic [31:0]      u;
    } t_item;

    // one evaluated point as the block should return it
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        fb;
        logic        wz;
    } t_curve_pt;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;     // slot, point_x, point_y, knot_value, weight_value, u_param, pad
    logic [1:0]   s_tuser;     // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;     // curve_x, curve_y
    logic [1:0]   m_tuser;     // fallback, weight_zero
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    rational_bspline_point_eval uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the stores and registers
    logic signed [31:0] ctl_x [NPTS];
    logic signed [31:0] ctl_y [NPTS];
    logic [23:0]        ctl_w [NPTS];
    logic signed [31:0] knots [NKNOT];
    logic [2:0]         reg_degree;
    logic [6:0]         reg_count;
    logic               reg_rational;

    t_curve_pt pending_pts[$];   // points still owed by the block
    int        err_count;
    int        items_sent;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_left;
    bit        hold_req;

    // clock and timeout
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint knot_at(input int i);
        return (i < NKNOT) ? longint'(knots[i]) : 0;
    endfunction

    // alpha in q0.16, rounded and clamped to [0, 1.0]
    function automatic longint alpha_q16(input longint num, input longint den);
        longint an, ad, q;
        if (den == 0 || num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an * ONE_Q16 + ad / 2) / ad;
        return (q > ONE_Q16) ? ONE_Q16 : q;
    endfunction

    function automatic longint blend_q16(input longint prev, input longint cur, input longint a);
        return round_q16((ONE_Q16 - a) * prev + a * cur);
    endfunction

    // homogeneous to cartesian, rounding half away from zero
    function automatic logic [31:0] dehomog(input longint h, input longint w);
        longint ah, q;
        ah = (h < 0) ? -h : h;
        q = (ah * ONE_Q16 + w / 2) / w;
        if (q > (64'sd1 <<< 56)) q = 64'sd1 <<< 56;
        return sat32((h < 0) ? -q : q);
    endfunction

    function automatic t_curve_pt eval_curve(input logic signed [31:0] u_raw);
        t_curve_pt res;
        int p, cnt, n, k, idx;
        longint u, lo, hi, w, a, base;
        longint dx [8];
        longint dy [8];
        longint dw [8];
        res = '0;
        p = reg_degree;
        cnt = (reg_count > NPTS) ? NPTS : reg_count;
        // too few points: first point, or zero when empty
        if (cnt < p + 1) begin
            res.fb = 1'b1;
            if (cnt != 0) begin
                res.x = ctl_x[0];
                res.y = ctl_y[0];
            end
            return res;
        end
        n = cnt - 1;
        u = u_raw;
        lo = knot_at(p);
        hi = knot_at(n + 1);
        // upper bound wins when the range is reversed
        if (u < lo) u = lo;
        if (u > hi) u = hi;
        k = n;
        for (int i = p; i <= n; i++) begin
            if (u >= knot_at(i) && u < knot_at(i + 1)) begin
                k = i;
                break;
            end
        end
        for (int j = 0; j <= p; j++) begin
            idx = k - p + j;
            w = reg_rational ? longint'(ctl_w[idx]) : ONE_Q16;
            dx[j] = round_q16(longint'(ctl_x[idx]) * w);
            dy[j] = round_q16(longint'(ctl_y[idx]) * w);
            dw[j] = w;
        end
        for (int r = 1; r <= p; r++) begin
            for (int j = p; j >= r; j--) begin
                idx = k - p + j;
                base = knot_at(idx);
                a = alpha_q16(u - base, knot_at(idx + p - r + 1) - base);
                dx[j] = blend_q16(dx[j-1], dx[j], a);
                dy[j] = blend_q16(dy[j-1], dy[j], a);
                dw[j] = blend_q16(dw[j-1], dw[j], a);
            end
        end
        if (dw[p] == 0) begin
            res.wz = 1'b1;
            res.x = sat32(dx[p]);
            res.y = sat32(dy[p]);
        end else begin
            res.x = dehomog(dx[p], dw[p]);
            res.y = dehomog(dy[p], dw[p]);
        end
        return res;
    endfunction

    // apply an accepted transaction to the predictor
    function automatic void predict_item(input t_item it);
        case (it.cmd)
            rbspe_pkg::CMD_POINT: begin
                if (it.slot < NPTS) begin
                    ctl_x[it.slot] = it.px;
                    ctl_y[it.slot] = it.py;
                end
            end
            rbspe_pkg::CMD_KNOT: begin
                if (it.slot < NKNOT) knots[it.slot] = it.knot;
            end
            rbspe_pkg::CMD_WEIGHT: begin
                if (it.slot < NPTS) ctl_w[it.slot] = it.wgt;
            end
            default: begin
                pending_pts.push_back(eval_curve(it.u));
            end
        endcase
    endfunction

    // ---------------- result side ----------------

    task automatic check_point();
        t_curve_pt want;
        if (pending_pts.size() == 0) begin
            $display("mismatch: unexpected result %h at %0t", m_tdata, $realtime);
            err_count++;
        end else begin
            want = pending_pts.pop_front();
            if (m_tdata[31:0] !== want.x) report_mismatch("curve_x", m_tdata[31:0], want.x);
            if (m_tdata[63:32] !== want.y) report_mismatch("curve_y", m_tdata[63:32], want.y);
            if (m_tuser[0] !== want.fb) report_mismatch("fallback", m_tuser[0], want.fb);
            if (m_tuser[1] !== want.wz) report_mismatch("weight_zero", m_tuser[1], want.wz);
        end
    endtask

    // receiver: checks each result transaction, stalls at random or for a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) check_point();
        if (hold_req) begin
            hold_left = 3000;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic t_item random_item(input rbspe_pkg::t_cmd cmd);
        t_item it;
        it.cmd = cmd;
        it.slot = $urandom_range(0, 127);
        it.px = $urandom;
        it.py = $urandom;
        it.knot = $urandom;
        it.wgt = $urandom;
        it.u = $urandom;
        return it;
    endfunction

    // one input transaction; valid stays high into the next item unless an idle gap follows
    task automatic send_item(input t_item it);
        s_tdata <= {1'b0, it.u, it.wgt, it.knot, it.py, it.px, it.slot};
        s_tuser <= it.cmd;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_point(input int slot, input logic [31:0] x, input logic [31:0] y);
        t_item it;
        it = random_item(rbspe_pkg::CMD_POINT);
        it.slot = slot;
        it.px = x;
        it.py = y;
        send_item(it);
    endtask

    task automatic write_knot(input int slot, input logic [31:0] v);
        t_item it;
        it = random_item(rbspe_pkg::CMD_KNOT);
        it.slot = slot;
        it.knot = v;
        send_item(it);
    endtask

    task automatic write_weight(input int slot, input logic [23:0] v);
        t_item it;
        it = random_item(rbspe_pkg::CMD_WEIGHT);
        it.slot = slot;
        it.wgt = v;
        send_item(it);
    endtask

    task automatic eval_at(input logic [31:0] u);
        t_item it;
        it = random_item(rbspe_pkg::CMD_EVAL);
        it.u = u;
        send_item(it);
    endtask

    // wait until every owed point has come back, then let write transactions settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write over the apb port, only with the block idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            rbspe_pkg::CFG_DEGREE: reg_degree = value[2:0];
            rbspe_pkg::CFG_COUNT:  reg_count = value[6:0];
            default:               reg_rational = value[0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_curve(input int deg, input int cnt, input bit rational);
        reg_write(rbspe_pkg::CFG_DEGREE, deg);
        reg_write(rbspe_pkg::CFG_COUNT, cnt);
        reg_write(rbspe_pkg::CFG_RATIONAL, rational);
    endtask

    // ---------------- tests ----------------

    // every store entry gets written first, so nothing unwritten is ever read
    task automatic test_fill_stores();
        for (int i = 0; i < NKNOT; i++) write_knot(i, i * 65536);
        for (int i = 0; i < NPTS; i++) begin
            write_point(i, $urandom_range(0, 200) << 16, $urandom_range(0, 200) << 16);
            write_weight(i, ONE_Q16);
        end
        // slots beyond each store are ignored
        write_point(100, 32'hdead_beef, 32'h1234_5678);
        write_knot(72, 32'h7fff_0000);
        write_knot(127, 32'h8000_0000);
        write_weight(64, 24'hffffff);
    endtask

    task automatic test_fallback();
        set_curve(3, 0, 0);
        eval_at(32'h0001_0000);                 // no points at all
        set_curve(3, 2, 0);
        eval_at(32'h0001_0000);                 // too few points, first one returned
        set_curve(0, 1, 1);
        eval_at(32'h0000_8000);                 // degree zero, single point
        set_curve(7, 127, 1);
        eval_at(32'h0010_0000);                 // oversized count taken as full store
        set_curve(7, 64, 0);
        eval_at(32'h7fff_ffff);
    endtask

    task automatic test_eval_cases();
        set_curve(3, 8, 0);
        eval_at(32'h8000_0000);                 // clamps to the low end
        eval_at(32'h7fff_ffff);                 // clamps to the high end
        eval_at(32'h0005_0000);                 // exactly on a knot
        write_point(4, 32'h7fff_ffff, 32'h8000_0000);
        eval_at(32'h0005_8000);                 // extreme coordinates
        write_knot(5, 32'h0004_0000);           // repeated knot, zero span
        eval_at(32'h0004_0000);
        write_knot(3, 32'h0009_0000);           // reversed range, unsorted knots
        eval_at(32'h0006_0000);
        write_knot(3, 32'h0003_0000);
        write_knot(5, 32'h0005_0000);
        set_curve(3, 8, 1);
        for (int i = 0; i < 8; i++) write_weight(i, 0);
        eval_at(32'h0004_8000);                 // zero final weight
        write_weight(3, 24'hffffff);
        eval_at(32'h0004_8000);                 // largest weight
    endtask

    // well-formed curve with random content, some noise and broken setups mixed in
    task automatic random_curve();
        int deg, cnt, eff, last;
        longint kv, lo, hi;
        bit rational;
        deg = $urandom_range(0, 7);
        case ($urandom_range(0, 19))
            0:       cnt = $urandom_range(0, deg);          // invalid setup
            1:       cnt = 64;
            2:       cnt = $urandom_range(65, 127);
            default: cnt = $urandom_range(deg + 1, (deg + 12 > 64) ? 64 : deg + 12);
        endcase
        rational = $urandom_range(0, 1);
        set_curve(deg, cnt, rational);
        eff = (cnt > NPTS) ? NPTS : cnt;
        last = eff + deg;
        if (last > NKNOT - 1) last = NKNOT - 1;
        kv = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        for (int i = 0; i <= last; i++) begin
            if ($urandom_range(0, 99) < 8) write_knot(i, $urandom);
            else write_knot(i, kv);
            if ($urandom_range(0, 3) != 0) kv += $urandom_range(1, 1 << 20);
        end
        for (int i = 0; i < eff; i++) begin
            if ($urandom_range(0, 3) == 0) write_point(i, $urandom, $urandom);
            else write_point(i, $urandom_range(0, 1 << 22) - (1 << 21),
                             $urandom_range(0, 1 << 22) - (1 << 21));
            if (rational) begin
                case ($urandom_range(0, 9))
                    0:       write_weight(i, 0);
                    1:       write_weight(i, ONE_Q16);
                    default: write_weight(i, $urandom);
                endcase
            end
        end
        lo = knot_at(deg);
        hi = knot_at(eff);
        repeat ($urandom_range(4, 10)) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_item(rbspe_pkg::t_cmd'($urandom_range(1, 3))));
            end else if (hi > lo && $urandom_range(0, 9) != 0) begin
                eval_at(lo + (longint'($urandom) % (hi - lo + 1)));
            end else begin
                eval_at($urandom);
            end
        end
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int quota);
        int stop_at;
        drain();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) random_curve();
    endtask

    // receiver holds off while evaluations keep coming, so the input side backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_curve(2, 10, 1);
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) eval_at(32'h0000_4000 + i * 32'h0001_0000);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= rbspe_pkg::CMD_EVAL;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        err_count = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        hold_req = 1'b0;
        reg_degree = rbspe_pkg::DEGREE_RST;
        reg_count = '0;
        reg_rational = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_stores();
        test_fallback();
        test_eval_cases();
        test_random(0, 0, 300);
        test_random(57, 0, 300);
        test_random(0, 57, 300);
        test_random(31, 31, 300);
        test_backpressure();
        test_random(0, 0, 100);

        drain();
        repeat (1000) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
